### design/gf_alu_pkg.sv
package gf_alu_pkg;

	localparam int FeW = 255;
	localparam logic [FeW-1:0] Prime = {1'b0, 254'd0} - 255'd19;
	localparam logic [FeW-1:0] InvExp = Prime - 255'd2;
	localparam logic [FeW-1:0] RootExp = (Prime - 255'd5) >> 3;

	typedef enum logic [2:0] {
		CMD_ADD = 3'd0,
		CMD_SUB = 3'd1,
		CMD_MUL = 3'd2,
		CMD_SQR = 3'd3,
		CMD_NEG = 3'd4,
		CMD_INV = 3'd5,
		CMD_ROOT = 3'd6,
		CMD_PASS = 3'd7
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SQ,
		ST_ML,
		ST_WAIT,
		ST_DONE
	} state_t;

	typedef enum logic [2:0] {
		MP_IDLE,
		MP_MAC,
		MP_TOP,
		MP_RED,
		MP_FOLD1,
		MP_FOLD2,
		MP_TRIM,
		MP_DONE
	} mul_phase_t;

	typedef struct packed {
		logic [2:0] command;
		logic [63:0] a_word0;
		logic [63:0] a_word1;
		logic [63:0] a_word2;
		logic [62:0] a_word3;
		logic [63:0] b_word0;
		logic [63:0] b_word1;
		logic [63:0] b_word2;
		logic [62:0] b_word3;
	} in_item_t;

	typedef struct packed {
		logic [63:0] r_word0;
		logic [63:0] r_word1;
		logic [63:0] r_word2;
		logic [62:0] r_word3;
		logic result_is_zero;
		logic result_is_odd;
	} out_item_t;

	// One canonical trim: subtract p when value >= p.
	function automatic logic [FeW:0] gf_trim(input logic [FeW:0] x);
		logic [FeW+1:0] d;
		d = {1'b0, x} - {2'b00, Prime};
		return d[FeW+1] ? x : d[FeW:0];
	endfunction

endpackage

### design/gf_alu_mul.sv
module gf_alu_mul import gf_alu_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic go,
	input logic [FeW-1:0] x,
	input logic [FeW-1:0] y,
	output logic done,
	output logic [FeW-1:0] p
);

	// Field multiplier on one 32x32 multiplier: 64 word products in column
	// order, then a word-serial 38x fold of the high half, two folds at bit
	// 255 and a trim. Done is high in the MP_DONE phase, which follows the trim.
	mul_phase_t phase_q, phase_d;
	logic [255:0] x_q, y_q;
	logic [511:0] prod_q;
	logic [255:0] r_q;
	logic [69:0] mac_q;
	logic [7:0] c_q;
	logic [3:0] col_q, col_n, j_full;
	logic [2:0] i_q, w_q, i_hi, i_lo_n, j;
	logic [31:0] xw, yw, lo_w, hi_w;
	logic [63:0] wp;
	logic [69:0] mac_sum;
	logic [39:0] red_sum;
	logic [8:0] top9;
	logic [10:0] top19;
	logic [FeW:0] fold1, fold2, trm;
	logic col_end;

	assign i_hi = col_q[3] ? 3'd7 : col_q[2:0];
	assign col_n = col_q + 4'd1;
	assign i_lo_n = col_n[3] ? col_n[2:0] + 3'd1 : 3'd0;
	assign j_full = col_q - {1'b0, i_q};
	assign j = j_full[2:0];
	assign col_end = i_q == i_hi;

	assign xw = x_q[{i_q, 5'd0} +: 32];
	assign yw = y_q[{j, 5'd0} +: 32];
	assign wp = {32'd0, xw} * {32'd0, yw};
	assign mac_sum = mac_q + {6'd0, wp};

	// 2^256 = 38 mod p
	assign lo_w = prod_q[{1'b0, w_q, 5'd0} +: 32];
	assign hi_w = prod_q[{1'b1, w_q, 5'd0} +: 32];
	assign red_sum = {8'd0, lo_w} + {3'd0, hi_w, 5'd0} + {6'd0, hi_w, 2'd0}
		+ {7'd0, hi_w, 1'b0} + {32'd0, c_q};

	// 2^255 = 19 mod p
	assign top9 = {c_q, r_q[255]};
	assign top19 = {2'd0, top9} * 11'd19;
	assign fold1 = {1'b0, r_q[254:0]} + {245'd0, top19};
	assign fold2 = {1'b0, r_q[254:0]} + {251'd0, r_q[255] ? 5'd19 : 5'd0};
	assign trm = gf_trim(r_q);

	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			MP_IDLE: phase_d = MP_IDLE;
			MP_MAC: if (col_end && col_q == 4'd14) phase_d = MP_TOP;
			MP_TOP: phase_d = MP_RED;
			MP_RED: if (w_q == 3'd7) phase_d = MP_FOLD1;
			MP_FOLD1: phase_d = MP_FOLD2;
			MP_FOLD2: phase_d = MP_TRIM;
			MP_TRIM: phase_d = MP_DONE;
			MP_DONE: phase_d = MP_IDLE;
			default: phase_d = MP_IDLE;
		endcase
		if (go) phase_d = MP_MAC;
	end

	always_comb begin
		done = phase_q == MP_DONE;
		p = r_q[FeW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= MP_IDLE;
		end else begin
			phase_q <= phase_d;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			x_q <= {1'b0, x};
			y_q <= {1'b0, y};
			mac_q <= '0;
			col_q <= '0;
			i_q <= '0;
		end else begin
			unique case (phase_q)
				MP_MAC: begin
					if (col_end) begin
						prod_q <= {mac_sum[31:0], prod_q[511:32]};
						mac_q <= {32'd0, mac_sum[69:32]};
						col_q <= col_n;
						i_q <= i_lo_n;
					end else begin
						mac_q <= mac_sum;
						i_q <= i_q + 3'd1;
					end
				end
				MP_TOP: begin
					prod_q <= {mac_q[31:0], prod_q[511:32]};
					w_q <= '0;
					c_q <= '0;
				end
				MP_RED: begin
					r_q <= {red_sum[31:0], r_q[255:32]};
					c_q <= red_sum[39:32];
					w_q <= w_q + 3'd1;
				end
				MP_FOLD1: r_q <= fold1;
				MP_FOLD2: r_q <= fold2;
				MP_TRIM: r_q <= trm;
				default: begin
				end
			endcase
		end
	end

endmodule

### design/gf25519_field_alu_top.sv
// Add/sub/neg/pass finish without the multiplier; mul/square take one multiply,
// and invert and the (p-5)/8 power a chain of square and multiply steps; each
// multiply runs on one shared 32x32 multiplier (invert: 508 of them).
// One item at a time: busy is high from transfer until the done cycle, and the
// next transfer can land in that cycle. The receiver cannot stall.
// Reset (arst_n low) clears control state only.
module gf25519_field_alu_top import gf_alu_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input in_item_t in_item,
	output logic busy,
	output logic done,
	output out_item_t out_item
);

	state_t state_q, state_d;
	cmd_t cmd_q;
	logic [FeW-1:0] a_q, b_q, acc_q, mx, my;
	logic [FeW-1:0] exp_q;
	logic [7:0] bit_q;
	logic ml_q;
	logic mgo, mdone;
	logic [FeW:0] la, lb, sum, sm, df, s_q, trm;
	logic [FeW-1:0] dfr;
	logic [FeW-1:0] mx_out;

	assign la = gf_trim({1'b0, in_item.a_word3, in_item.a_word2,
		in_item.a_word1, in_item.a_word0});
	assign lb = gf_trim({1'b0, in_item.b_word3, in_item.b_word2,
		in_item.b_word1, in_item.b_word0});

	gf_alu_mul u_mul (.clk, .arst_n, .go(mgo), .x(mx), .y(my), .done(mdone), .p(mx_out));

	assign sum = {1'b0, a_q} + {1'b0, b_q};
	// bit 255 is the borrow
	assign df = {1'b0, (cmd_q == CMD_NEG) ? {FeW{1'b0}} : a_q} - {1'b0,
		(cmd_q == CMD_NEG) ? a_q : b_q};
	assign trm = gf_trim(s_q);
	assign dfr = s_q[FeW] ? s_q[FeW-1:0] + Prime : s_q[FeW-1:0];

	always_comb begin
		unique case (state_q)
			ST_IDLE: state_d = start ? ST_LOAD : ST_IDLE;
			ST_LOAD: begin
				unique case (cmd_q)
					CMD_MUL, CMD_SQR, CMD_INV, CMD_ROOT: state_d = ST_WAIT;
					default: state_d = ST_DONE;
				endcase
			end
			ST_SQ: state_d = ST_WAIT;
			ST_ML: state_d = ST_WAIT;
			ST_WAIT: state_d = ST_WAIT;
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
		if (state_q == ST_WAIT && mdone) begin
			if (cmd_q == CMD_MUL || cmd_q == CMD_SQR) state_d = ST_DONE;
			else if (!ml_q && exp_q[bit_q]) state_d = ST_ML;
			else if (bit_q == 8'd0) state_d = ST_DONE;
			else state_d = ST_SQ;
		end
	end

	always_comb begin
		mgo = (state_q == ST_LOAD && (cmd_q == CMD_MUL || cmd_q == CMD_SQR
			|| cmd_q == CMD_INV || cmd_q == CMD_ROOT)) || state_q == ST_SQ
			|| state_q == ST_ML;
		mx = (state_q == ST_LOAD && (cmd_q == CMD_MUL || cmd_q == CMD_SQR)) ? a_q : acc_q;
		my = (state_q == ST_ML) ? a_q : (state_q == ST_LOAD && cmd_q == CMD_MUL) ? b_q
			: (state_q == ST_LOAD && cmd_q == CMD_SQR) ? a_q : acc_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done <= 1'b0;
		end else begin
			state_q <= state_d;
			done <= state_q == ST_DONE;
		end
	end

	// ml_q marks that the multiply just finished was the multiply-by-a step
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			cmd_q <= cmd_t'(in_item.command);
			a_q <= la[FeW-1:0];
			b_q <= lb[FeW-1:0];
			exp_q <= (cmd_t'(in_item.command) == CMD_INV) ? InvExp : RootExp;
			bit_q <= 8'd254;
			acc_q <= {{(FeW-1){1'b0}}, 1'b1};
		end
		if (state_q == ST_LOAD || state_q == ST_SQ) ml_q <= 1'b0;
		if (state_q == ST_ML) ml_q <= 1'b1;
		if (state_q == ST_WAIT && mdone) begin
			acc_q <= mx_out;
			if ((ml_q || !exp_q[bit_q]) && bit_q != 8'd0) bit_q <= bit_q - 8'd1;
		end
		if (state_q == ST_LOAD) begin
			s_q <= (cmd_q == CMD_ADD) ? sum : df;
		end
		if (state_q == ST_DONE) begin
			unique case (cmd_q)
				CMD_ADD: acc_q <= trm[FeW-1:0];
				CMD_SUB, CMD_NEG: acc_q <= dfr;
				CMD_PASS: acc_q <= a_q;
				default: acc_q <= acc_q;
			endcase
		end
	end

	assign sm = {1'b0, acc_q};
	always_comb begin
		out_item.r_word0 = sm[63:0];
		out_item.r_word1 = sm[127:64];
		out_item.r_word2 = sm[191:128];
		out_item.r_word3 = sm[254:192];
		out_item.result_is_zero = acc_q == '0;
		out_item.result_is_odd = acc_q[0];
	end
	assign busy = state_q != ST_IDLE;

	ap_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("strobe while busy");
	ap_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("transfer not taken");
	ap_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |=> done) else $error("no strobe");
	ap_canon: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> acc_q < Prime) else $error("non-canonical");

endmodule
